/* sv/svss_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted vertex set store package
// Shared widths, action codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package svss_pkg;

    // Parameter defaults for the top level.
    localparam int CAPACITY_DEF    = 64;
    localparam int VERTEX_BITS_DEF = 32;

    // Fixed field widths of the item channels.
    localparam int ACTION_W = 3;
    localparam int VERTEX_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_AFTER  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BEFORE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ALL    = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

endpackage

/* sv/sorted_vertex_set_store_top.sv */
// ----------------------------------------------------------------------------
// Sorted vertex set store
// Holds up to CAPACITY distinct vertex numbers in ascending order in one RAM
// and serves clear, insert, query and three list actions on them.
// ----------------------------------------------------------------------------
// Usage:
// Input items (i_action, i_vertex) enter on i_in_valid / o_in_stall; result
// items leave on o_out_valid / i_out_stall. An item is taken while the
// control sits idle; one item is worked on at a time. Results come from an
// output register, so the next item is taken while the last result waits.
// Steps, with N the number of stored elements:
//   clear and unused codes: go straight to S_EMIT, which loads the result.
//   insert, query, list after, list before: a binary search over the RAM,
//   each probe a read (S_SRD), then a compare (S_SCMP), for up to
//   ceil(log2(N+1)) probes, then a dispatch (S_DISP); insert moves each element
//   up with one RAM read and one RAM write and ends with the final write.
//   list actions then give each result by a read (S_LRD), then a load (S_LOUT).
// The RAM, with one read port and one write port, sets this order of steps.
// Reset clears the element count and the control; the RAM is not cleared,
// since only entries below the count are ever read. A stalled receiver holds
// the result register and the block waits with it.
// ----------------------------------------------------------------------------
module sorted_vertex_set_store_top #(
    parameter int CAPACITY    = svss_pkg::CAPACITY_DEF,
    parameter int VERTEX_BITS = svss_pkg::VERTEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [svss_pkg::ACTION_W-1:0] i_action,
    input  logic [svss_pkg::VERTEX_W-1:0] i_vertex,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [svss_pkg::STATUS_W-1:0] o_status,
    output logic                          o_has_element,
    output logic [svss_pkg::VERTEX_W-1:0] o_element,
    output logic [svss_pkg::COUNT_W-1:0]  o_stored_count,
    output logic                          o_last
);

    localparam int SW = (VERTEX_BITS < svss_pkg::VERTEX_W) ? VERTEX_BITS : svss_pkg::VERTEX_W;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SRD  = 9'b000000010,
        S_SCMP = 9'b000000100,
        S_DISP = 9'b000001000,
        S_SHRD = 9'b000010000,
        S_SHWR = 9'b000100000,
        S_LRD  = 9'b001000000,
        S_LOUT = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    t_state                          r_state, n_state;
    logic [svss_pkg::ACTION_W-1:0]   r_action, n_action;
    logic [SW-1:0]                   r_vert, n_vert;
    logic [CW-1:0]                   r_lo, n_lo;
    logic [CW-1:0]                   r_hi, n_hi;
    logic                            r_found, n_found;
    logic [CW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_end, n_end;
    logic [CW-1:0]                   r_count, n_count;
    logic [svss_pkg::STATUS_W-1:0]   r_pend, n_pend;

    logic                            r_out_valid, n_out_valid;
    logic [svss_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic                            r_out_has, n_out_has;
    logic [svss_pkg::VERTEX_W-1:0]   r_out_elem, n_out_elem;
    logic [svss_pkg::COUNT_W-1:0]    r_out_count, n_out_count;
    logic                            r_out_last, n_out_last;

    logic                            ram_wr_en;
    logic [AW-1:0]                   ram_wr_addr;
    logic [SW-1:0]                   ram_wr_data;
    logic                            ram_rd_en;
    logic [AW-1:0]                   ram_rd_addr;
    logic [SW-1:0]                   ram_rd_data;

    logic                            in_acc;
    logic                            out_free;
    logic [CW:0]                     mid_sum;
    logic [CW-1:0]                   mid;
    logic [CW-1:0]                   idx_inc;
    logic [CW-1:0]                   idx_dec;
    logic [CW-1:0]                   pos_inc;

    // Element storage.
    svss_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Handshake helpers and search midpoint.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mid_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid        = mid_sum[CW:1];
    assign idx_inc    = r_idx + CW'(1);
    assign idx_dec    = r_idx - CW'(1);
    assign pos_inc    = r_lo + CW'(1);

    // Control sequencer: search, shift, list and result loading.
    always_comb begin
        n_state      = r_state;
        n_action     = r_action;
        n_vert       = r_vert;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_found      = r_found;
        n_idx        = r_idx;
        n_end        = r_end;
        n_count      = r_count;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_has    = r_out_has;
        n_out_elem   = r_out_elem;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_idx[AW-1:0];
        ram_wr_data  = ram_rd_data;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = mid[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action = i_action;
                    n_vert   = i_vertex[SW-1:0];
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_found  = 1'b0;
                    n_pend   = svss_pkg::ST_DONE;
                    priority if (i_action == svss_pkg::ACT_CLEAR) begin
                        n_count = '0;
                        n_state = S_EMIT;
                    end else if (i_action == svss_pkg::ACT_ALL) begin
                        n_idx   = '0;
                        n_end   = r_count;
                        n_state = (r_count == '0) ? S_EMIT : S_LRD;
                    end else if (i_action == svss_pkg::ACT_INSERT
                              || i_action == svss_pkg::ACT_QUERY
                              || i_action == svss_pkg::ACT_AFTER
                              || i_action == svss_pkg::ACT_BEFORE) begin
                        n_state = S_SRD;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SRD: begin
                if (r_lo < r_hi) begin
                    ram_rd_en = 1'b1;
                    n_state   = S_SCMP;
                end else begin
                    n_state = S_DISP;
                end
            end
            S_SCMP: begin
                if (ram_rd_data < r_vert) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                if (ram_rd_data == r_vert) begin
                    n_found = 1'b1;
                end
                n_state = S_SRD;
            end
            S_DISP: begin
                n_state = S_EMIT;
                priority if (r_action == svss_pkg::ACT_INSERT) begin
                    if (r_found) begin
                        n_pend = svss_pkg::ST_DUP;
                    end else if (r_count >= CAP_C) begin
                        n_pend = svss_pkg::ST_FULL;
                    end else begin
                        n_idx   = r_count;
                        n_state = S_SHRD;
                    end
                end else if (!r_found) begin
                    n_pend = svss_pkg::ST_ABSENT;
                end else if (r_action == svss_pkg::ACT_AFTER) begin
                    n_idx = pos_inc;
                    n_end = r_count;
                    if (pos_inc < r_count) begin
                        n_state = S_LRD;
                    end
                end else if (r_action == svss_pkg::ACT_BEFORE) begin
                    n_idx = '0;
                    n_end = r_lo;
                    if (r_lo != '0) begin
                        n_state = S_LRD;
                    end
                end else begin
                    n_pend = svss_pkg::ST_DONE;
                end
            end
            S_SHRD: begin
                // Move entries at and above the insertion point up, top first.
                if (r_idx > r_lo) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_dec[AW-1:0];
                    n_state     = S_SHWR;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_lo[AW-1:0];
                    ram_wr_data = r_vert;
                    n_count     = r_count + CW'(1);
                    n_state     = S_EMIT;
                end
            end
            S_SHWR: begin
                ram_wr_en = 1'b1;
                n_idx     = idx_dec;
                n_state   = S_SHRD;
            end
            S_LRD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_idx[AW-1:0];
                n_state     = S_LOUT;
            end
            S_LOUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = svss_pkg::ST_DONE;
                    n_out_has    = 1'b1;
                    n_out_elem   = svss_pkg::VERTEX_W'(ram_rd_data);
                    n_out_count  = svss_pkg::COUNT_W'(r_count);
                    n_out_last   = (idx_inc == r_end);
                    n_idx        = idx_inc;
                    n_state      = (idx_inc == r_end) ? S_IDLE : S_LRD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_pend;
                    n_out_has    = 1'b0;
                    n_out_elem   = '0;
                    n_out_count  = svss_pkg::COUNT_W'(r_count);
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_vert       <= n_vert;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_found      <= n_found;
        r_idx        <= n_idx;
        r_end        <= n_end;
        r_pend       <= n_pend;
        r_out_status <= n_out_status;
        r_out_has    <= n_out_has;
        r_out_elem   <= n_out_elem;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_has_element  = r_out_has;
    assign o_element      = r_out_elem;
    assign o_stored_count = r_out_count;
    assign o_last         = r_out_last;

    // The count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("element count above capacity");

    // A shift write never lands at or below the insertion point.
    a_shift_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHWR) |-> (r_idx > r_lo))
        else $error("shift write below insertion point");

    // Listing stays inside its range.
    a_list_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOUT) |-> (r_idx < r_end))
        else $error("list index out of range");

    // A listed element always carries the done status.
    a_elem_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_has_element) |-> (o_status == svss_pkg::ST_DONE))
        else $error("listed element with a non-done status");

    // The count changes only on a clear or at the end of an insert.
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (($past(r_state) == S_SHRD)
            || ($past(in_acc) && ($past(i_action) == svss_pkg::ACT_CLEAR))))
        else $error("element count changed outside clear or insert");

endmodule

/* sv/svss_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// its value in cycles without a read. Contents are undefined until written.
// ----------------------------------------------------------------------------
module svss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
